### hdl/unicycle_line_tracking_control_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unicycle line tracking controller
// Concurrent checks sampled on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNICYCLE_LINE_TRACKING_CONTROL_TOP_ASSERT_SVH
`define UNICYCLE_LINE_TRACKING_CONTROL_TOP_ASSERT_SVH

// same-cycle implication
`define ULTC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ultc check failed");

// next-cycle implication
`define ULTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ultc check failed");

`endif

### hdl/ultc_pkg.sv
// ----------------------------------------------------------------------------
// ultc_pkg
// Types, fixed-point constants and helper functions of the line tracking
// controller.
// ----------------------------------------------------------------------------
package ultc_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int ANG_W = 36;        // Q.30 angles, unwrapped range
	localparam int CW = 34;           // CORDIC x/y/z word
	localparam int DIV_BITS = 30;     // sinc quotient bits
	localparam int SNC_W = 31;        // sinc, unsigned Q.30 in [0, 1]
	localparam int DEN_W = 32;        // divider denominator/remainder

	localparam logic signed [ANG_W-1:0] ANG_PI = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 36'sd6746518852;
	localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
	localparam logic [SNC_W-1:0] SNC_ONE = 31'h4000_0000;

	localparam logic signed [31:0] CMD_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] CMD_MIN = 32'sh8000_0000;

	// configuration register indexes
	localparam logic [1:0] REG_POSITION_GAIN = 2'd0;
	localparam logic [1:0] REG_HEADING_GAIN = 2'd1;
	localparam logic [1:0] REG_REF_SPEED = 2'd2;
	localparam logic [1:0] REG_REF_TURN_RATE = 2'd3;

	typedef struct packed {
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [15:0] cur_heading;
		logic signed [31:0] des_x;
		logic signed [31:0] des_y;
		logic signed [15:0] des_heading;
	} in_t;

	typedef struct packed {
		logic signed [31:0] lin_cmd;
		logic signed [31:0] ang_cmd;
		logic saturated;
	} out_t;

	// arctangent of 2^-i, Q.30
	function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
		logic signed [CW-1:0] r;
		case (idx)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			10: r = 34'sd1048576;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

	// first half of the wrap into (-pi, pi]: pull down from above
	function automatic logic signed [ANG_W-1:0] wrap_hi(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		r = a;
		if (r > ANG_PI) r = r - ANG_TWO_PI;
		if (r > ANG_PI) r = r - ANG_TWO_PI;
		return r;
	endfunction

	// second half: push up from below
	function automatic logic signed [ANG_W-1:0] wrap_lo(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		r = a;
		if (r <= -ANG_PI) r = r + ANG_TWO_PI;
		if (r <= -ANG_PI) r = r + ANG_TWO_PI;
		return r;
	endfunction

endpackage

### hdl/unicycle_line_tracking_control_top.sv
// ----------------------------------------------------------------------------
// unicycle_line_tracking_control_top
// Fixed-point unicycle trajectory tracking controller, fully pipelined.
// ----------------------------------------------------------------------------
// One pose pair (actual and desired) goes in per transaction, one pair of
// velocity commands comes out per transaction. The pipeline takes a new
// transaction every clock cycle while in_stall is low. Most of its depth is
// the CORDIC pipeline for sin/cos of heading, mean heading and half heading
// error, followed by the divider with 30 quotient-bit stages that forms
// sinc of the half heading error. Every stage keeps a valid bit and a stage
// advances whenever the stage after it is free or moving, so bubbles close up
// and in_stall only rises once the whole pipe is full behind a stalled output.
// Configuration writes go straight into the gain/feedforward registers and
// are meant to be done while the pipe is empty.
module unicycle_line_tracking_control_top
	import ultc_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	localparam int COR_LAT = CORDIC_STAGES + 4;
	localparam int DIV_LAT = DIV_BITS + 2;
	localparam int ST_COR = 3;
	localparam int ST_DIV = ST_COR + COR_LAT;
	localparam int ST_M1 = ST_DIV + DIV_LAT;
	localparam int NSTG = ST_M1 + 6;

	localparam int XW = 33;     // position error
	localparam int PW = 67;     // error times sin/cos
	localparam int PE_W = 38;   // projected errors, Q16.16
	localparam int HT_W = 32;   // heading term
	localparam int LIN_W = 48;
	localparam int ANGC_W = 50;
	localparam int QH = 19;     // split point of |q| for the two partials
	localparam int PP_W = 52;
	localparam int FULL_W = 71;
	localparam int LIM_W = 63;
	localparam logic [FULL_W-1:0] PROD_LIMIT = 71'h4000_0000_0000_0000;

	typedef struct packed {
		logic signed [XW-1:0] ex;
		logic signed [XW-1:0] ey;
		logic signed [ANG_W-1:0] eth;
	} side_t;

	typedef struct packed {
		logic signed [PE_W-1:0] q;
		logic signed [HT_W-1:0] hterm;
		logic signed [LIN_W-1:0] lin;
	} mid_t;

	// configuration
	logic [15:0] pos_gain_q, head_gain_q;
	logic signed [31:0] ref_speed_q, ref_turn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_gain_q <= 16'd256;
			head_gain_q <= 16'd256;
			ref_speed_q <= 32'sd32768;
			ref_turn_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POSITION_GAIN: pos_gain_q <= cfg_data[15:0];
				REG_HEADING_GAIN: head_gain_q <= cfg_data[15:0];
				REG_REF_SPEED: ref_speed_q <= cfg_data;
				REG_REF_TURN_RATE: ref_turn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits and per-stage advance
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
		for (int k = NSTG - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall = !en[0];
	assign out_valid = vld_q[NSTG-1];

	// stage 1: errors and Q.30 angles
	logic signed [XW-1:0] ex_s1, ey_s1, ex_s2, ey_s2, ex_s3, ey_s3;
	logic signed [ANG_W-1:0] th_s1, al_s1, dif_s1;
	logic signed [ANG_W-1:0] th_s2, al_s2, dif_s2;
	logic signed [ANG_W-1:0] th_s3, al_s3, eth_s3, h_s3;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ex_s1 <= XW'(in_data.cur_x) - XW'(in_data.des_x);
			ey_s1 <= XW'(in_data.cur_y) - XW'(in_data.des_y);
			th_s1 <= ANG_W'(in_data.cur_heading) <<< 17;
			al_s1 <= ANG_W'(17'(in_data.cur_heading) + 17'(in_data.des_heading)) <<< 16;
			dif_s1 <= (ANG_W'(in_data.cur_heading) - ANG_W'(in_data.des_heading)) <<< 17;
		end
		if (en[1]) begin
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;
			th_s2 <= th_s1;
			al_s2 <= al_s1;
			dif_s2 <= wrap_hi(dif_s1);
		end
		if (en[2]) begin
			ex_s3 <= ex_s2;
			ey_s3 <= ey_s2;
			th_s3 <= th_s2;
			al_s3 <= al_s2;
			eth_s3 <= wrap_lo(dif_s2);
			h_s3 <= wrap_lo(dif_s2) >>> 1;   // exact: heading error is even
		end
	end

	// three CORDICs side by side
	logic signed [CW-1:0] st, ct, sa, ca, sh, ch_unused;

	ultc_cordic #(.STAGES(CORDIC_STAGES)) u_cor_th (
		.clk(clk), .en(en[ST_COR +: COR_LAT]), .angle(th_s3),
		.sin_val(st), .cos_val(ct)
	);

	ultc_cordic #(.STAGES(CORDIC_STAGES)) u_cor_al (
		.clk(clk), .en(en[ST_COR +: COR_LAT]), .angle(al_s3),
		.sin_val(sa), .cos_val(ca)
	);

	ultc_cordic #(.STAGES(CORDIC_STAGES)) u_cor_h (
		.clk(clk), .en(en[ST_COR +: COR_LAT]), .angle(h_s3),
		.sin_val(sh), .cos_val(ch_unused)
	);

	// errors ride alongside the CORDICs
	side_t side_s [ST_COR:ST_DIV-1];

	for (genvar k = ST_COR; k < ST_DIV; k++) begin : g_side
		if (k == ST_COR) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) side_s[k] <= '{ex: ex_s3, ey: ey_s3, eth: eth_s3};
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en[k]) side_s[k] <= side_s[k-1];
			end
		end
	end

	// sinc(h) divider
	logic [SNC_W-1:0] snc;

	ultc_div u_div (
		.clk(clk), .en(en[ST_DIV +: DIV_LAT]), .sh(sh),
		.h(side_s[ST_DIV-1].eth >>> 1), .snc(snc)
	);

	// projections, in parallel with the divider
	logic signed [PW-1:0] p_ect_s1, p_est_s1, p_eca_s1, p_esa_s1;
	logic signed [52:0] p_hg_s1;
	logic signed [PE_W-1:0] pe_s2, q_s2;
	logic signed [HT_W-1:0] ht_s2;
	logic signed [53:0] sum_pe, sum_q;
	logic signed [54:0] lin_prod;

	always_ff @(posedge clk) begin
		if (en[ST_DIV]) begin
			p_ect_s1 <= side_s[ST_DIV-1].ex * ct;
			p_est_s1 <= side_s[ST_DIV-1].ey * st;
			p_eca_s1 <= side_s[ST_DIV-1].ey * ca;
			p_esa_s1 <= side_s[ST_DIV-1].ex * sa;
			p_hg_s1 <= $signed({1'b0, head_gain_q}) * side_s[ST_DIV-1].eth;
		end
	end

	always_comb begin
		sum_pe = 54'(p_ect_s1 >>> 14) + 54'(p_est_s1 >>> 14);
		sum_q = 54'(p_eca_s1 >>> 14) - 54'(p_esa_s1 >>> 14);
		lin_prod = $signed({1'b0, pos_gain_q}) * pe_s2;
	end

	always_ff @(posedge clk) begin
		if (en[ST_DIV+1]) begin
			pe_s2 <= PE_W'(sum_pe >>> 16);
			q_s2 <= PE_W'(sum_q >>> 16);
			ht_s2 <= HT_W'(p_hg_s1 >>> 22);
		end
	end

	mid_t mid_s [ST_DIV+2:ST_M1+4];

	for (genvar k = ST_DIV + 2; k <= ST_M1 + 4; k++) begin : g_mid
		if (k == ST_DIV + 2) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					mid_s[k] <= '{q: q_s2, hterm: ht_s2,
						lin: LIN_W'(ref_speed_q) - LIN_W'(lin_prod >>> 8)};
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en[k]) mid_s[k] <= mid_s[k-1];
			end
		end
	end

	// speed times sinc times q, limited, then commands
	logic signed [63:0] vsp_m1;
	logic [XW-1:0] avs_m2;
	logic [PE_W-1:0] aq_m2;
	logic neg_m2, neg_m3, neg_m4;
	logic [PP_W-1:0] pp_lo_m3, pp_hi_m3;
	logic [LIM_W-1:0] p_m4;
	logic signed [ANGC_W-1:0] ang_m5;
	logic signed [33:0] vs;
	logic [FULL_W-1:0] full;
	logic signed [63:0] sp;
	logic signed [ANGC_W-1:0] ang_pre;
	logic lin_hi, lin_lo, ang_hi, ang_lo;
	logic signed [LIN_W-1:0] lin_fin;
	out_t out_q;

	always_comb begin
		vs = 34'(vsp_m1 >>> 30);
		full = (FULL_W'(pp_hi_m3) << QH) + FULL_W'(pp_lo_m3);
		sp = neg_m4 ? -$signed({1'b0, p_m4}) : $signed({1'b0, p_m4});
		ang_pre = ANGC_W'(ref_turn_q) - ANGC_W'(mid_s[ST_M1+3].hterm)
			- ANGC_W'(sp >>> 16);
		lin_fin = mid_s[ST_M1+4].lin;
		lin_hi = lin_fin > LIN_W'(CMD_MAX);
		lin_lo = lin_fin < LIN_W'(CMD_MIN);
		ang_hi = ang_m5 > ANGC_W'(CMD_MAX);
		ang_lo = ang_m5 < ANGC_W'(CMD_MIN);
	end

	always_ff @(posedge clk) begin
		if (en[ST_M1]) vsp_m1 <= ref_speed_q * $signed({1'b0, snc});
		if (en[ST_M1+1]) begin
			avs_m2 <= vs < 0 ? XW'(-vs) : XW'(vs);
			aq_m2 <= mid_s[ST_M1].q < 0 ? PE_W'(-mid_s[ST_M1].q) : PE_W'(mid_s[ST_M1].q);
			neg_m2 <= (vs < 0) != (mid_s[ST_M1].q < 0);
		end
		if (en[ST_M1+2]) begin
			pp_lo_m3 <= avs_m2 * aq_m2[QH-1:0];
			pp_hi_m3 <= avs_m2 * aq_m2[PE_W-1:QH];
			neg_m3 <= neg_m2;
		end
		if (en[ST_M1+3]) begin
			p_m4 <= full > PROD_LIMIT ? LIM_W'(PROD_LIMIT) : full[LIM_W-1:0];
			neg_m4 <= neg_m3;
		end
		if (en[ST_M1+4]) ang_m5 <= ang_pre;
		if (en[ST_M1+5]) begin
			out_q.lin_cmd <= lin_hi ? CMD_MAX : lin_lo ? CMD_MIN : lin_fin[31:0];
			out_q.ang_cmd <= ang_hi ? CMD_MAX : ang_lo ? CMD_MIN : ang_m5[31:0];
			out_q.saturated <= lin_hi || lin_lo || ang_hi || ang_lo;
		end
	end

	assign out_data = out_q;

endmodule

### hdl/ultc_cordic.sv
// ----------------------------------------------------------------------------
// ultc_cordic
// Pipelined rotation CORDIC: wrap, quadrant fold, one micro-rotation per
// stage, sign restore. Each stage loads on its own enable bit.
// ----------------------------------------------------------------------------
module ultc_cordic
	import ultc_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                        clk,
	input  logic [STAGES+3:0]           en,
	input  logic signed [ANG_W-1:0]     angle,
	output logic signed [CW-1:0]        sin_val,
	output logic signed [CW-1:0]        cos_val
);

	logic signed [ANG_W-1:0] ang_s1, ang_s2;
	logic signed [CW-1:0] x_s [0:STAGES];
	logic signed [CW-1:0] y_s [0:STAGES];
	logic signed [CW-1:0] z_s [0:STAGES];
	logic neg_s [0:STAGES];
	logic signed [ANG_W-1:0] fold_z;
	logic fold_neg;

	always_comb begin
		fold_z = ang_s2;
		fold_neg = 1'b0;
		if (ang_s2 > ANG_HALF_PI) begin
			fold_z = ang_s2 - ANG_PI;
			fold_neg = 1'b1;
		end else if (ang_s2 < -ANG_HALF_PI) begin
			fold_z = ang_s2 + ANG_PI;
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) ang_s1 <= wrap_hi(angle);
		if (en[1]) ang_s2 <= wrap_lo(ang_s1);
		if (en[2]) begin
			z_s[0] <= CW'(fold_z);
			neg_s[0] <= fold_neg;
			x_s[0] <= CORDIC_K;
			y_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en[3+i]) begin
				neg_s[i+1] <= neg_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[STAGES+3]) begin
			sin_val <= neg_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
			cos_val <= neg_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
		end
	end

endmodule

### hdl/ultc_div.sv
// ----------------------------------------------------------------------------
// ultc_div
// Pipelined restoring divider for sinc = sin(h) * 2^30 / h, clamped to
// [0, 1] in Q.30. One quotient bit per stage.
// ----------------------------------------------------------------------------
module ultc_div
	import ultc_pkg::*;
(
	input  logic                    clk,
	input  logic [DIV_BITS+1:0]     en,
	input  logic signed [CW-1:0]    sh,
	input  logic signed [ANG_W-1:0] h,
	output logic [SNC_W-1:0]        snc
);

	logic [DEN_W-1:0] r_s [0:DIV_BITS];
	logic [DEN_W-1:0] d_s [0:DIV_BITS];
	logic [DIV_BITS-1:0] q_s [0:DIV_BITS];
	logic one_s [0:DIV_BITS];
	logic zero_s [0:DIV_BITS];

	logic [CW-1:0] ash;
	logic [ANG_W-1:0] ah;
	logic sgn_diff;

	always_comb begin
		ash = sh < 0 ? CW'(-sh) : CW'(sh);
		ah = h < 0 ? ANG_W'(-h) : ANG_W'(h);
		sgn_diff = (sh < 0) != (h < 0);
	end

	// |h| <= pi/2 so it fits the denominator; if the remainder does not start below it, the result is clamped
	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s[0] <= DEN_W'(ash);
			d_s[0] <= DEN_W'(ah);
			q_s[0] <= '0;
			one_s[0] <= (h == 0) || (!sgn_diff && ({{(ANG_W-CW){1'b0}}, ash} >= ah));
			zero_s[0] <= (h != 0) && sgn_diff;
		end
	end

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
		logic [DEN_W:0] r2;
		logic take;
		always_comb begin
			r2 = {r_s[i], 1'b0};
			take = r2 >= {1'b0, d_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en[1+i]) begin
				r_s[i+1] <= take ? DEN_W'(r2 - {1'b0, d_s[i]}) : r2[DEN_W-1:0];
				d_s[i+1] <= d_s[i];
				q_s[i+1] <= {q_s[i][DIV_BITS-2:0], take};
				one_s[i+1] <= one_s[i];
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_BITS+1]) begin
			if (one_s[DIV_BITS]) snc <= SNC_ONE;
			else if (zero_s[DIV_BITS]) snc <= '0;
			else snc <= SNC_W'(q_s[DIV_BITS]);
		end
	end

endmodule

### hdl/ultc_checker.sv
// ----------------------------------------------------------------------------
// ultc_checker
// Port-level checks of the line tracking controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "unicycle_line_tracking_control_top_assert.svh"

module ultc_checker
	import ultc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// a held transaction stays offered
	`ULTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// and keeps its payload
	`ULTC_ASSERT_NEXT(a_data_hold, out_valid && out_stall, $stable(out_data))
	// with the output free the pipe always moves, so input is never stalled
	`ULTC_ASSERT_SAME(a_free_flow, !out_stall, !in_stall)
	// the clip flag means a command sits at a rail
	`ULTC_ASSERT_SAME(a_sat_rail, out_valid && out_data.saturated, out_data.lin_cmd == CMD_MAX || out_data.lin_cmd == CMD_MIN || out_data.ang_cmd == CMD_MAX || out_data.ang_cmd == CMD_MIN)

endmodule

bind unicycle_line_tracking_control_top ultc_checker u_ultc_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Line tracking controller testbench
// Random and directed pose pairs are pushed through the pipeline under
// random input gaps and output stalls. Every command pair is checked against
// a cycle-free fixed-point predictor of the control law.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import ultc_pkg::*;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint GAIN_K = 64'sd652032874;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam longint unsigned PROD_CAP = 64'h4000_0000_0000_0000;
	localparam int STAGES = 16;
	localparam int HDG_MAX = 25736;
	localparam int LONG_HOLD = 250;

	localparam longint ATAN_Q30 [0:15] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768
	};

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	// controller settings as the predictor sees them
	longint pos_gain, hdg_gain, speed_ff, turn_ff;

	in_t pose_q[$];        // pose pairs waiting to be offered
	out_t cmd_q[$];        // predicted command pairs, oldest first
	int errors;
	int n_accepted;
	bit quiet;             // no idling on either side
	bit taken;             // offered pose accepted at the last edge
	int gap_cnt, stall_cnt, hold_cnt;
	bit hold_done;

	unicycle_line_tracking_control_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------- predictor ----------------
	function automatic longint wrap_pi(longint a);
		if (a > PI_Q30) a -= TWO_PI_Q30;
		if (a > PI_Q30) a -= TWO_PI_Q30;
		if (a <= -PI_Q30) a += TWO_PI_Q30;
		if (a <= -PI_Q30) a += TWO_PI_Q30;
		return a;
	endfunction

	// rotation CORDIC, folded to the right half plane
	function automatic void rotate(input longint a, output longint s, output longint c);
		longint x, y, z, nx;
		bit flip;
		x = GAIN_K;
		y = 0;
		flip = 0;
		z = wrap_pi(a);
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_Q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_Q30[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint capped_mul(longint a, longint b);
		longint unsigned ua, ub, p;
		ua = (a < 0) ? longint'(-a) : a;
		ub = (b < 0) ? longint'(-b) : b;
		if (ua != 0 && ub > PROD_CAP / ua)
			p = PROD_CAP;
		else
			p = ua * ub;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic signed [31:0] clip32(longint v, inout logic hit);
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return CMD_MAX;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return CMD_MIN;
		end
		return v[31:0];
	endfunction

	function automatic out_t predict_cmds(in_t p);
		longint ex, ey, th, thd, eth, alpha, h;
		longint st, ct, sa, ca, sh, ch, snc, pe, q, vs, lin, ang;
		out_t r;
		ex = longint'(p.cur_x) - longint'(p.des_x);
		ey = longint'(p.cur_y) - longint'(p.des_y);
		th = longint'(p.cur_heading) * 131072;
		thd = longint'(p.des_heading) * 131072;
		eth = wrap_pi(th - thd);
		alpha = (th + thd) / 2;
		rotate(th, st, ct);
		rotate(alpha, sa, ca);
		pe = (((ex * ct) >>> 14) + ((ey * st) >>> 14)) >>> 16;
		q = (((ey * ca) >>> 14) - ((ex * sa) >>> 14)) >>> 16;
		h = eth / 2;
		if (h == 0) begin
			snc = UNIT_Q30;
		end else begin
			rotate(h, sh, ch);
			snc = (sh * UNIT_Q30) / h;
			if (snc > UNIT_Q30) snc = UNIT_Q30;
			if (snc < 0) snc = 0;
		end
		lin = speed_ff - ((pos_gain * pe) >>> 8);
		vs = (speed_ff * snc) >>> 30;
		ang = turn_ff - ((hdg_gain * eth) >>> 22) - (capped_mul(vs, q) >>> 16);
		r.saturated = 1'b0;
		r.lin_cmd = clip32(lin, r.saturated);
		r.ang_cmd = clip32(ang, r.saturated);
		return r;
	endfunction

	// ---------------- checking ----------------
	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s at %0t: got %0d expected %0d", what, $realtime, got, want);
	endtask

	// accepted transactions on both sides, sampled at the rising edge
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				cmd_q.push_back(predict_cmds(pose_q.pop_front()));
				taken = 1;
				n_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (cmd_q.size() == 0) begin
					errors++;
					$display("unexpected command transaction at %0t", $realtime);
				end else begin
					want = cmd_q.pop_front();
					if (out_data.lin_cmd !== want.lin_cmd)
						report("lin_cmd", out_data.lin_cmd, want.lin_cmd);
					if (out_data.ang_cmd !== want.ang_cmd)
						report("ang_cmd", out_data.ang_cmd, want.ang_cmd);
					if (out_data.saturated !== want.saturated)
						report("saturated", out_data.saturated, want.saturated);
				end
			end
		end
	end

	// ---------------- pose driver ----------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !taken) begin
				// still waiting for acceptance: hold payload
			end else if (gap_cnt > 0) begin
				gap_cnt--;
				in_valid <= 1'b0;
			end else if (!quiet && pose_q.size() > 0 && $urandom_range(0, 11) == 0) begin
				gap_cnt = $urandom_range(0, 12);
				in_valid <= 1'b0;
			end else if (pose_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pose_q[0];
			end else begin
				in_valid <= 1'b0;
			end
			taken = 0;
		end
	end

	// ---------------- command receiver ----------------
	// one long hold-off fills the pipe and backs up the input side
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_accepted >= 300) begin
				hold_done = 1;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_cnt = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_POSITION_GAIN: pos_gain = longint'(val[15:0]);
			REG_HEADING_GAIN: hdg_gain = longint'(val[15:0]);
			REG_REF_SPEED: speed_ff = longint'($signed(val));
			REG_REF_TURN_RATE: turn_ff = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic set_law(logic [15:0] kp, logic [15:0] kh, logic [31:0] v, logic [31:0] w);
		write_reg(REG_POSITION_GAIN, {16'h0, kp});
		write_reg(REG_HEADING_GAIN, {16'h0, kh});
		write_reg(REG_REF_SPEED, v);
		write_reg(REG_REF_TURN_RATE, w);
	endtask

	task automatic push_pose(int cx, int cy, int ch, int dx, int dy, int dh);
		in_t p;
		p.cur_x = cx;
		p.cur_y = cy;
		p.cur_heading = 16'(ch);
		p.des_x = dx;
		p.des_y = dy;
		p.des_heading = 16'(dh);
		pose_q.push_back(p);
	endtask

	// pipe empty, nothing pending
	task automatic drain();
		while (pose_q.size() > 0 || cmd_q.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	function automatic int rand_hdg();
		if ($urandom_range(0, 19) == 0)
			return $signed(16'($urandom()));
		return int'($urandom_range(0, 2 * HDG_MAX)) - HDG_MAX;
	endfunction

	function automatic int corner32();
		case ($urandom_range(0, 3))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 0;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_poses(int n);
		int dx, dy;
		repeat (n) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
					// tracking close to the reference
					dx = $urandom();
					dy = $urandom();
					push_pose(dx + int'($urandom_range(0, 262144)) - 131072,
						dy + int'($urandom_range(0, 262144)) - 131072, rand_hdg(),
						dx, dy, rand_hdg());
				end
				12, 13, 14, 15, 16:
					push_pose($urandom(), $urandom(), rand_hdg(),
						$urandom(), $urandom(), rand_hdg());
				default:
					push_pose(corner32(), corner32(), rand_hdg(),
						corner32(), corner32(), rand_hdg());
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		errors = 0;
		n_accepted = 0;
		quiet = 0;
		taken = 0;
		gap_cnt = 0;
		stall_cnt = 0;
		hold_cnt = 0;
		hold_done = 0;
		pos_gain = 256;
		hdg_gain = 256;
		speed_ff = 32768;
		turn_ff = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed poses under the reset law
		push_pose(0, 0, 0, 0, 0, 0);                          // zero error, zero bearing
		push_pose(65536, 0, 0, 0, 0, 0);
		push_pose(0, 65536, 0, 0, 0, 0);
		push_pose(0, 0, HDG_MAX, 0, 0, HDG_MAX);
		push_pose(0, 0, -HDG_MAX, 0, 0, -HDG_MAX);
		push_pose(0, 0, HDG_MAX, 0, 0, -HDG_MAX);             // heading error wraps
		push_pose(0, 0, -HDG_MAX, 0, 0, HDG_MAX);
		push_pose(0, 0, 12868, 0, 0, -12868);
		push_pose(0, 0, 1, 0, 0, 0);                          // smallest heading error
		push_pose(0, 0, 2, 0, 0, 0);
		push_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 0,
			32'sh8000_0000, 32'sh8000_0000, 0);                  // largest errors
		push_pose(32'sh8000_0000, 32'sh8000_0000, HDG_MAX,
			32'sh7fff_ffff, 32'sh7fff_ffff, -HDG_MAX);
		push_pose(32'sh8000_0000, 0, 6434, 32'sh7fff_ffff, 0, 6434);
		push_pose(0, 32'sh7fff_ffff, -6434, 0, 32'sh8000_0000, 19302);
		push_pose(-1, -1, -1, 0, 0, 0);
		push_pose(100, -100, 32767, -100, 100, -32768);       // headings beyond pi
		push_pose(0, 0, -32768, 0, 0, 32767);
		push_pose(1 << 20, -(1 << 20), 3000, 0, 0, -3000);
		drain();

		// gains and feedforward at their extremes, then fixed and random settings
		set_law(16'h0000, 16'h0000, 32'h8000_0000, 32'h8000_0000);
		random_poses(150);
		drain();
		set_law(16'hffff, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff);
		random_poses(250);
		drain();
		set_law(16'd256, 16'd512, 32'h0001_0000, 32'hffff_8000);
		random_poses(350);
		drain();
		for (int k = 0; k < 2; k++) begin
			set_law(16'($urandom()), 16'($urandom()), $urandom(), $urandom());
			random_poses(120);
			drain();
		end
		set_law(16'h00ff, 16'h0100, 32'hfffe_0000, 32'h0000_0000);
		random_poses(100);
		drain();

		// closing stretch without idling
		quiet = 1;
		set_law(16'($urandom()), 16'($urandom()), $urandom(), $urandom());
		random_poses(120);
		drain();
		repeat (80) @(posedge clk);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
